### rtl/core/gtp_pkg.sv
// ----------------------------------------------------------------------------
// gtp_pkg: shared types and constants of the gyro to pointer converter
// Register map, mode codes, controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package gtp_pkg;

  localparam int unsigned CURVE_POINTS_DEF = 64;
  localparam int unsigned FRAC_BITS_DEF    = 16;

  // dividend width of the shared divider: covers n*points<<16
  localparam int unsigned DIV_W      = 48;
  localparam int unsigned MOUSE_DIV  = 1000;
  localparam int unsigned SMOOTH_MAX = 243;
  localparam int unsigned JOY_MAX    = 32767;

  localparam logic [1:0] MODE_JOY   = 2'd1;
  localparam logic [1:0] MODE_MOUSE = 2'd2;

  localparam logic [2:0] REG_GYRO_MODE  = 3'd0;
  localparam logic [2:0] REG_FLAGS      = 3'd1;
  localparam logic [2:0] REG_DEADZONE   = 3'd2;
  localparam logic [2:0] REG_SENS_X     = 3'd3;
  localparam logic [2:0] REG_SENS_Y     = 3'd4;
  localparam logic [2:0] REG_SMOOTHING  = 3'd5;
  localparam logic [2:0] REG_BIAS_YAW   = 3'd6;
  localparam logic [2:0] REG_BIAS_PITCH = 3'd7;

  localparam logic signed [55:0] V40_MAX = 56'sh00_007F_FFFF_FFFF;
  localparam logic signed [55:0] V40_MIN = 56'shFF_FF80_0000_0000;

  typedef struct packed {
    logic [1:0]         gyro_mode;
    logic [2:0]         flags;
    logic [14:0]        deadzone;
    logic [15:0]        sens_x;
    logic [15:0]        sens_y;
    logic [7:0]         smoothing;
    logic signed [15:0] bias_yaw;
    logic signed [15:0] bias_pitch;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic tbl_we;
    logic clr;
    logic axis;
    logic front;
    logic div_curve;
    logic div_mouse;
    logic cap_idx;
    logic rd_next;
    logic cap_t0;
    logic cap_t1;
    logic interp;
    logic mag;
    logic scale;
    logic joy;
    logic smooth;
    logic vel;
    logic accum;
    logic split;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic use_curve;
    logic curve_sat;
    logic div_done;
  } stat_t;

  function automatic logic signed [39:0] sat40(input logic signed [55:0] v);
    logic signed [39:0] r;
    if (v > V40_MAX) r = V40_MAX[39:0];
    else if (v < V40_MIN) r = V40_MIN[39:0];
    else r = v[39:0];
    return r;
  endfunction

endpackage

### rtl/core/gtp_ram.sv
// ----------------------------------------------------------------------------
// gtp_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gtp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 65
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/core/gtp_div.sv
// ----------------------------------------------------------------------------
// gtp_div: restoring divider, one quotient bit per cycle
// Unsigned dividend of DW bits over a nonzero 16-bit divisor.
// ----------------------------------------------------------------------------
module gtp_div #(
  parameter int unsigned DW = 48
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [15:0]   divisor_i,
  output logic [DW-1:0] quot_o,
  output logic          done_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW-1:0] q_q;
  logic [15:0]   r_q;
  logic [15:0]   d_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [16:0]   shifted, diff;
  logic          ge;

  always_comb begin
    shifted = {r_q, q_q[DW-1]};
    ge      = shifted >= {1'b0, d_q};
    diff    = shifted - {1'b0, d_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= dividend_i;
      r_q <= '0;
      d_q <= divisor_i;
    end else if (busy_q) begin
      q_q <= {q_q[DW-2:0], ge};
      r_q <= ge ? diff[15:0] : shifted[15:0];
    end
  end

  assign quot_o = q_q;
  assign done_o = done_q;

endmodule

### rtl/core/gtp_regs.sv
// ----------------------------------------------------------------------------
// gtp_regs: APB configuration registers
// Eight registers at word addresses, write on the access phase.
// ----------------------------------------------------------------------------
module gtp_regs
  import gtp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;
  logic wr;

  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{gyro_mode: 2'd0, flags: 3'd0, deadzone: 15'd0, sens_x: 16'd256,
                 sens_y: 16'd256, smoothing: 8'd0, bias_yaw: 16'sd0, bias_pitch: 16'sd0};
    end else if (wr) begin
      unique case (paddr[4:2])
        REG_GYRO_MODE:  cfg_q.gyro_mode  <= pwdata[1:0];
        REG_FLAGS:      cfg_q.flags      <= pwdata[2:0];
        REG_DEADZONE:   cfg_q.deadzone   <= pwdata[14:0];
        REG_SENS_X:     cfg_q.sens_x     <= pwdata[15:0];
        REG_SENS_Y:     cfg_q.sens_y     <= pwdata[15:0];
        REG_SMOOTHING:  cfg_q.smoothing  <= pwdata[7:0];
        REG_BIAS_YAW:   cfg_q.bias_yaw   <= $signed(pwdata[15:0]);
        REG_BIAS_PITCH: cfg_q.bias_pitch <= $signed(pwdata[15:0]);
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_GYRO_MODE:  prdata = {30'b0, cfg_q.gyro_mode};
      REG_FLAGS:      prdata = {29'b0, cfg_q.flags};
      REG_DEADZONE:   prdata = {17'b0, cfg_q.deadzone};
      REG_SENS_X:     prdata = {16'b0, cfg_q.sens_x};
      REG_SENS_Y:     prdata = {16'b0, cfg_q.sens_y};
      REG_SMOOTHING:  prdata = {24'b0, cfg_q.smoothing};
      REG_BIAS_YAW:   prdata = {{16{cfg_q.bias_yaw[15]}}, cfg_q.bias_yaw};
      REG_BIAS_PITCH: prdata = {{16{cfg_q.bias_pitch[15]}}, cfg_q.bias_pitch};
    endcase
  end

endmodule

### rtl/core/gtp_ctrl.sv
// ----------------------------------------------------------------------------
// gtp_ctrl: sequencer of the converter
// Walks each axis through front end, curve, scale, joystick or mouse filter.
// ----------------------------------------------------------------------------
module gtp_ctrl
  import gtp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       in_op_i,
  input  logic [1:0] mode_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  input  stat_t      stat_i,
  output cmd_t       cmd_o
);

  typedef enum logic [19:0] {
    ST_IDLE   = 20'h00001,
    ST_WRITE  = 20'h00002,
    ST_OFF    = 20'h00004,
    ST_FRONT  = 20'h00008,
    ST_SHAPE  = 20'h00010,
    ST_CWAIT  = 20'h00020,
    ST_RDA    = 20'h00040,
    ST_RDB    = 20'h00080,
    ST_RDC    = 20'h00100,
    ST_INTERP = 20'h00200,
    ST_MAG    = 20'h00400,
    ST_SCALE  = 20'h00800,
    ST_JOY    = 20'h01000,
    ST_MDIV   = 20'h02000,
    ST_MWAIT  = 20'h04000,
    ST_SMOOTH = 20'h08000,
    ST_VEL    = 20'h10000,
    ST_ACCUM  = 20'h20000,
    ST_SPLIT  = 20'h40000,
    ST_DONE   = 20'h80000
  } state_e;

  state_e state_q, state_d;
  logic   axis_q, axis_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d   = state_q;
    axis_d    = axis_q;
    cmd_o      = '0;
    cmd_o.axis = axis_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          axis_d     = 1'b0;
          if (in_op_i) state_d = ST_WRITE;
          else if (mode_i == MODE_JOY || mode_i == MODE_MOUSE) state_d = ST_FRONT;
          else state_d = ST_OFF;
        end
      end
      ST_WRITE: begin
        cmd_o.tbl_we = 1'b1;
        state_d      = ST_DONE;
      end
      ST_OFF: begin
        cmd_o.clr = 1'b1;
        state_d   = ST_DONE;
      end
      ST_FRONT: begin
        cmd_o.front = 1'b1;
        state_d     = ST_SHAPE;
      end
      ST_SHAPE: begin
        if (!stat_i.use_curve) state_d = ST_MAG;
        else if (stat_i.curve_sat) state_d = ST_RDA;
        else begin
          cmd_o.div_curve = 1'b1;
          state_d         = ST_CWAIT;
        end
      end
      ST_CWAIT: begin
        if (stat_i.div_done) begin
          cmd_o.cap_idx = 1'b1;
          state_d       = ST_RDA;
        end
      end
      ST_RDA: state_d = ST_RDB;
      ST_RDB: begin
        cmd_o.cap_t0  = 1'b1;
        cmd_o.rd_next = 1'b1;
        state_d       = ST_RDC;
      end
      ST_RDC: begin
        cmd_o.cap_t1 = 1'b1;
        state_d      = ST_INTERP;
      end
      ST_INTERP: begin
        cmd_o.interp = 1'b1;
        state_d      = ST_MAG;
      end
      ST_MAG: begin
        cmd_o.mag = 1'b1;
        state_d   = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = (mode_i == MODE_JOY) ? ST_JOY : ST_MDIV;
      end
      ST_JOY: begin
        cmd_o.joy = 1'b1;
        axis_d    = 1'b1;
        state_d   = axis_q ? ST_DONE : ST_FRONT;
      end
      ST_MDIV: begin
        cmd_o.div_mouse = 1'b1;
        state_d         = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (stat_i.div_done) state_d = ST_SMOOTH;
      end
      ST_SMOOTH: begin
        cmd_o.smooth = 1'b1;
        state_d      = ST_VEL;
      end
      ST_VEL: begin
        cmd_o.vel = 1'b1;
        state_d   = ST_ACCUM;
      end
      ST_ACCUM: begin
        cmd_o.accum = 1'b1;
        state_d     = ST_SPLIT;
      end
      ST_SPLIT: begin
        cmd_o.split = 1'b1;
        axis_d      = 1'b1;
        state_d     = axis_q ? ST_DONE : ST_FRONT;
      end
      ST_DONE: begin
        // output register free or being emptied this cycle
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### rtl/core/gtp_dp.sv
// ----------------------------------------------------------------------------
// gtp_dp: datapath of the converter
// Shared front end, curve lookup, scaler, dividers and per-axis filter state.
// ----------------------------------------------------------------------------
module gtp_dp
  import gtp_pkg::*;
#(
  parameter int unsigned CURVE_POINTS = CURVE_POINTS_DEF,
  parameter int unsigned FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  cmd_t               cmd_i,
  output stat_t              stat_o,
  input  logic signed [15:0] rate_yaw_i,
  input  logic signed [15:0] rate_pitch_i,
  input  logic [6:0]         entry_index_i,
  input  logic [15:0]        entry_value_i,
  output logic               move_valid_o,
  output logic signed [15:0] mouse_dx_o,
  output logic signed [15:0] mouse_dy_o,
  output logic signed [15:0] stick_x_o,
  output logic signed [15:0] stick_y_o
);

  localparam int unsigned IW  = $clog2(CURVE_POINTS + 1);
  localparam int unsigned SHR = 24 - FRAC_BITS;
  localparam logic signed [40:0] RND = (41'sd1 <<< FRAC_BITS) - 41'sd1;
  // ceil(2^52 / 125): exact floor(y/125) for y below 2^45
  localparam logic [47:0] RCP125 = 48'h20C4_9BA5_E354;

  // captured input word
  logic signed [15:0] yaw_q, pitch_q;
  logic [6:0]         idx_q;
  logic [15:0]        val_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      yaw_q   <= rate_yaw_i;
      pitch_q <= rate_pitch_i;
      idx_q   <= entry_index_i;
      val_q   <= entry_value_i;
    end
  end

  // front end: bias, negate, deadzone
  logic signed [15:0] rate_s, bias_s;
  logic signed [16:0] g;
  logic [16:0]        g_mag;
  logic [15:0]        a_f, dz16, n_d, range16;
  logic               in_dz, neg_f, use_c, csat;

  always_comb begin
    rate_s  = cmd_i.axis ? pitch_q : yaw_q;
    bias_s  = cmd_i.axis ? cfg_i.bias_pitch : cfg_i.bias_yaw;
    g       = $signed({bias_s[15], bias_s}) - $signed({rate_s[15], rate_s});
    g_mag   = g[16] ? (~g + 17'd1) : g;
    dz16    = {1'b0, cfg_i.deadzone};
    in_dz   = g_mag[15:0] < dz16;
    a_f     = in_dz ? 16'd0 : g_mag[15:0];
    neg_f   = (in_dz ? 1'b0 : g[16]) ^ cfg_i.flags[cmd_i.axis];
    range16 = 16'(17'h08000 - {2'b0, cfg_i.deadzone});
    n_d     = a_f - dz16;
    use_c   = cfg_i.flags[2] && (a_f > dz16);
    csat    = n_d >= range16;
  end

  logic [15:0] a_q, n_q;
  logic        neg_q, use_c_q, csat_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.front) begin
      a_q     <= a_f;
      n_q     <= n_d;
      neg_q   <= neg_f;
      use_c_q <= use_c;
      csat_q  <= csat;
    end
  end

  // curve position divider, divisor set by the deadzone
  logic [DIV_W-1:0] dvd, quot;
  logic [15:0]      dvs;
  logic             div_done;
  logic [47:0]      prod_q;

  always_comb begin
    dvd = (DIV_W'(n_q) * DIV_W'(CURVE_POINTS)) << 16;
    dvs = range16;
  end

  gtp_div #(.DW(DIV_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_curve),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .quot_o     (quot),
    .done_o     (div_done)
  );

  // divide by 1000: (x >> 3) / 125 by reciprocal, one 16-bit slice of the
  // reciprocal per cycle, low slice first, low bits dropped as they settle
  logic [44:0] y_q;
  logic [61:0] racc_q, rsum;
  logic [1:0]  rstep_q;
  logic        rbusy_q, rdone_q;
  logic [15:0] rslice;
  logic [39:0] mq;

  always_comb begin
    unique case (rstep_q)
      2'd0:    rslice = RCP125[15:0];
      2'd1:    rslice = RCP125[31:16];
      default: rslice = RCP125[47:32];
    endcase
    rsum = (racc_q >> 16) + ({17'b0, y_q} * {46'b0, rslice});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rbusy_q <= 1'b0;
      rdone_q <= 1'b0;
      rstep_q <= '0;
    end else begin
      rdone_q <= 1'b0;
      if (cmd_i.div_mouse) begin
        rbusy_q <= 1'b1;
        rstep_q <= '0;
      end else if (rbusy_q) begin
        rstep_q <= rstep_q + 2'd1;
        if (rstep_q == 2'd2) begin
          rbusy_q <= 1'b0;
          rdone_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_mouse) begin
      y_q    <= 45'(prod_q >> (SHR + 3));
      racc_q <= '0;
    end else if (rbusy_q) begin
      racc_q <= rsum;
    end
  end

  assign mq = racc_q[59:20];

  assign stat_o.use_curve = use_c_q;
  assign stat_o.curve_sat = csat_q;
  assign stat_o.div_done  = div_done || rdone_q;

  // curve table
  logic [IW-1:0]       cidx_q, raddr, waddr;
  logic [15:0]         f_q, t0_q, t1_q, c_q, rdata;
  logic [DIV_W-17:0]   ihi;
  logic                we;

  assign ihi   = quot[DIV_W-1:16];
  assign waddr = IW'(idx_q);
  assign we    = cmd_i.tbl_we && (32'(idx_q) <= 32'(CURVE_POINTS));
  assign raddr = csat_q ? IW'(CURVE_POINTS) :
                 (cmd_i.rd_next ? IW'(cidx_q + IW'(1)) : cidx_q);

  gtp_ram #(.WIDTH(16), .DEPTH(CURVE_POINTS + 1)) u_curve (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (val_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  logic [16:0] w0;
  logic [33:0] isum;
  logic [31:0] mag_d, mag_q;
  logic [15:0] sens;

  always_comb begin
    w0    = 17'h10000 - {1'b0, f_q};
    isum  = ({18'b0, t0_q} * {17'b0, w0}) + ({18'b0, t1_q} * {18'b0, f_q});
    sens  = cmd_i.axis ? cfg_i.sens_y : cfg_i.sens_x;
    mag_d = use_c_q ? ({1'b0, cfg_i.deadzone, 16'b0} +
                       32'({16'b0, c_q} * {16'b0, range16}))
                    : {a_q, 16'b0};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_idx) begin
      cidx_q <= (ihi > (DIV_W-16)'(CURVE_POINTS - 1)) ? IW'(CURVE_POINTS - 1) : IW'(ihi);
      f_q    <= quot[15:0];
    end
    if (cmd_i.cap_t0) t0_q <= rdata;
    if (cmd_i.cap_t1) t1_q <= rdata;
    if (cmd_i.interp) c_q <= csat_q ? t0_q : isum[31:16];
    if (cmd_i.mag)    mag_q <= mag_d;
    if (cmd_i.scale)  prod_q <= {16'b0, mag_q} * {32'b0, sens};
  end

  // joystick axis: (prod*20) >> 24, saturated
  logic [52:0]        j20;
  logic [28:0]        jm;
  logic [14:0]        jsat;
  logic signed [15:0] jval;

  always_comb begin
    j20  = ({5'b0, prod_q} << 4) + ({5'b0, prod_q} << 2);
    jm   = j20[52:24];
    jsat = (jm > 29'(JOY_MAX)) ? 15'(JOY_MAX) : jm[14:0];
    jval = neg_q ? -$signed({1'b0, jsat}) : $signed({1'b0, jsat});
  end

  // mouse filter and accumulator
  logic signed [39:0] vel_q [2];
  logic signed [39:0] rem_q [2];
  logic signed [39:0] vel_sel, rem_sel, acc_q;
  logic signed [51:0] psum_q, pa, pb, tv, vq;
  logic signed [40:0] raw_s, ta, dq;
  logic [7:0]         s8;
  logic [8:0]         ws;
  logic signed [15:0] d16;
  logic signed [39:0] vel_new, rem_new;

  always_comb begin
    vel_sel = vel_q[cmd_i.axis];
    rem_sel = rem_q[cmd_i.axis];
    s8      = (cfg_i.smoothing > 8'(SMOOTH_MAX)) ? 8'(SMOOTH_MAX) : cfg_i.smoothing;
    ws      = 9'd256 - {1'b0, s8};
    raw_s   = neg_q ? -$signed({1'b0, mq}) : $signed({1'b0, mq});
    pa      = 52'(vel_sel) * 52'($signed({1'b0, s8}));
    pb      = 52'(raw_s) * 52'($signed({1'b0, ws}));
    // divide by 256 rounding toward zero
    tv      = psum_q[51] ? (psum_q + 52'sd255) : psum_q;
    vq      = tv >>> 8;
    vel_new = sat40(56'(vq));
    ta      = acc_q[39] ? (41'(acc_q) + RND) : 41'(acc_q);
    dq      = ta >>> FRAC_BITS;
    if (dq > 41'sd32767) d16 = 16'sh7FFF;
    else if (dq < -41'sd32768) d16 = 16'sh8000;
    else d16 = dq[15:0];
    rem_new = sat40(56'(acc_q) - (56'(d16) <<< FRAC_BITS));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.smooth) psum_q <= pa + pb;
    if (cmd_i.accum)  acc_q  <= sat40(56'(rem_sel) + 56'(vel_sel));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_q[0] <= '0;
      vel_q[1] <= '0;
      rem_q[0] <= '0;
      rem_q[1] <= '0;
    end else if (cmd_i.clr) begin
      vel_q[0] <= '0;
      vel_q[1] <= '0;
      rem_q[0] <= '0;
      rem_q[1] <= '0;
    end else begin
      if (cmd_i.vel)   vel_q[cmd_i.axis] <= vel_new;
      if (cmd_i.split) rem_q[cmd_i.axis] <= rem_new;
    end
  end

  // per-item results, then the output word register
  logic signed [15:0] dx_q, dy_q, sx_q, sy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dx_q <= '0;
      dy_q <= '0;
      sx_q <= '0;
      sy_q <= '0;
    end else begin
      if (cmd_i.joy) begin
        if (cmd_i.axis) sy_q <= jval;
        else sx_q <= jval;
      end
      if (cmd_i.split) begin
        if (cmd_i.axis) dy_q <= d16;
        else dx_q <= d16;
      end
    end
    if (cmd_i.out_load) begin
      move_valid_o <= (dx_q != 16'sd0) || (dy_q != 16'sd0);
      mouse_dx_o   <= dx_q;
      mouse_dy_o   <= dy_q;
      stick_x_o    <= sx_q;
      stick_y_o    <= sy_q;
    end
  end

endmodule

### rtl/core/gyro_to_pointer_converter.sv
// ----------------------------------------------------------------------------
// gyro_to_pointer_converter: gyro rates to stick axes or pointer deltas
// A curve write or off-mode sample takes a short path; a joystick or mouse
// sample runs each axis in turn through the steps, with a bit-serial curve
// division per axis when the curve is interpolated, and the finished word may
// wait on m_axis_tready. One word at a time: none is taken while one is in flight.
// Reset clears config, filter state and handshake; the curve table is not.
// ----------------------------------------------------------------------------
module gyro_to_pointer_converter
  import gtp_pkg::*;
#(
  parameter int unsigned CURVE_POINTS = CURVE_POINTS_DEF,
  parameter int unsigned FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // rate_yaw[15:0], rate_pitch[31:16], entry_index[38:32], entry_value[54:39]
  input  logic [55:0] s_axis_tdata,
  // operation[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // mouse_dx[15:0], mouse_dy[31:16], stick_x[47:32], stick_y[63:48]
  output logic [63:0] m_axis_tdata,
  // move_valid[0]
  output logic        m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;
  logic signed [15:0] dx, dy, sx, sy;

  gtp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  gtp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .mode_i      (cfg.gyro_mode),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  gtp_dp #(
    .CURVE_POINTS (CURVE_POINTS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .rate_yaw_i    ($signed(s_axis_tdata[15:0])),
    .rate_pitch_i  ($signed(s_axis_tdata[31:16])),
    .entry_index_i (s_axis_tdata[38:32]),
    .entry_value_i (s_axis_tdata[54:39]),
    .move_valid_o  (m_axis_tuser),
    .mouse_dx_o    (dx),
    .mouse_dy_o    (dy),
    .stick_x_o     (sx),
    .stick_y_o     (sy)
  );

  assign m_axis_tdata = {sy, sx, dy, dx};

endmodule

### rtl/core/gtp_checker.sv
// ----------------------------------------------------------------------------
// gtp_checker: port-level assertions for the converter
// Bound to the top level; watches handshakes and result words.
// ----------------------------------------------------------------------------
module gtp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // one word at a time: busy right after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("accepted a word while busy");

  a_move_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[31:0] != 32'd0)
    else $error("move flag without movement");

  // pointer and stick fields never both carry data
  a_mode_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[31:0] == 32'd0 || m_axis_tdata[63:32] == 32'd0)
    else $error("pointer and stick both set");

  a_stick_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[47:32] != 16'h8000 && m_axis_tdata[63:48] != 16'h8000)
    else $error("stick value out of range");

endmodule

bind gyro_to_pointer_converter gtp_checker u_gtp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for gyro_to_pointer_converter
// Random and directed gyro samples and curve writes go through the slave
// stream. A cycle-free predictor of the pointer/stick math holds the expected
// words, and every master word is compared against the oldest one.
// ----------------------------------------------------------------------------
module tb;
  import gtp_pkg::*;

  localparam int unsigned POINTS = CURVE_POINTS_DEF;
  localparam logic        OP_SAMPLE = 1'b0;
  localparam logic        OP_ENTRY  = 1'b1;
  localparam logic [1:0]  MODE_OFF  = 2'd0;
  localparam logic [1:0]  MODE_RSVD = 2'd3;
  localparam longint      V40_TOP   = 64'sd549755813887;

  typedef struct {
    logic               op;
    logic signed [15:0] yaw;
    logic signed [15:0] pitch;
    logic [6:0]         idx;
    logic [15:0]        val;
  } gyro_word_t;

  typedef struct {
    logic               moved;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
  } move_word_t;

  logic        clk_i, rst_ni;
  logic        s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [55:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready, m_axis_tuser;
  logic [63:0] m_axis_tdata;
  logic        psel, penable, pwrite, pready;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;

  gyro_to_pointer_converter dut (.*);

  gyro_word_t  tx_queue[$];
  move_word_t  moves_due[$];
  gyro_word_t  cur_word;
  int unsigned gap_pct, stall_pct;
  logic        hold_rx;
  int unsigned errors;

  // predictor state
  cfg_t        cfg;
  logic [15:0] curve[POINTS+1];
  longint      vel_x, vel_y, rem_x, rem_y;

  function automatic longint clamp40(longint v);
    if (v > V40_TOP) return V40_TOP;
    if (v < -V40_TOP - 1) return -V40_TOP - 1;
    return v;
  endfunction

  // bias minus rate, deadzone; returns magnitude, sign through neg
  function automatic int unsigned rate_mag(int rate, int bias, output bit neg);
    int g;
    int unsigned a;
    g = bias - rate;
    neg = g < 0;
    a = neg ? -g : g;
    if (a < cfg.deadzone) begin
      a = 0;
      neg = 0;
    end
    return a;
  endfunction

  function automatic longint unsigned curve_mag(int unsigned a);
    longint unsigned rng, n, c, p, i, f;
    if (!cfg.flags[2] || a <= cfg.deadzone) return longint'(a) << 16;
    rng = 32768 - cfg.deadzone;
    n = a - cfg.deadzone;
    if (n >= rng) c = curve[POINTS];
    else begin
      p = ((n * POINTS) << 16) / rng;
      i = p >> 16;
      f = p & 16'hFFFF;
      if (i >= POINTS) i = POINTS - 1;
      c = (curve[i] * (65536 - f) + curve[i+1] * f) >> 16;
    end
    return (longint'(cfg.deadzone) << 16) + c * rng;
  endfunction

  function automatic logic signed [15:0] stick_axis(longint unsigned m, int unsigned sens,
                                                     bit neg);
    longint unsigned v;
    v = (m * sens * 20) >> 24;
    if (v > JOY_MAX) v = JOY_MAX;
    return neg ? -v : v;
  endfunction

  function automatic logic signed [15:0] pointer_axis(longint unsigned m, int unsigned sens,
                                                       bit neg, inout longint vel,
                                                       inout longint rem);
    longint raw, s, acc, d;
    raw = ((m * sens) >> (24 - FRAC_BITS_DEF)) / MOUSE_DIV;
    s = (cfg.smoothing > SMOOTH_MAX) ? SMOOTH_MAX : cfg.smoothing;
    if (neg) raw = -raw;
    vel = clamp40((vel * s + raw * (256 - s)) / 256);
    acc = clamp40(rem + vel);
    d = acc / (64'sd1 << FRAC_BITS_DEF);
    if (d > 32767) d = 32767;
    if (d < -32768) d = -32768;
    rem = clamp40(acc - d * (64'sd1 << FRAC_BITS_DEF));
    return d;
  endfunction

  function automatic move_word_t predict_move(gyro_word_t w);
    move_word_t r;
    bit nx, ny;
    longint unsigned mx, my;
    r = '{default: '0};
    if (w.op == OP_ENTRY) begin
      if (w.idx <= POINTS) curve[w.idx] = w.val;
    end else if (cfg.gyro_mode == MODE_JOY || cfg.gyro_mode == MODE_MOUSE) begin
      mx = curve_mag(rate_mag(w.yaw, cfg.bias_yaw, nx));
      my = curve_mag(rate_mag(w.pitch, cfg.bias_pitch, ny));
      if (cfg.flags[0]) nx = !nx;
      if (cfg.flags[1]) ny = !ny;
      if (cfg.gyro_mode == MODE_JOY) begin
        r.sx = stick_axis(mx, cfg.sens_x, nx);
        r.sy = stick_axis(my, cfg.sens_y, ny);
      end else begin
        r.dx = pointer_axis(mx, cfg.sens_x, nx, vel_x, rem_x);
        r.dy = pointer_axis(my, cfg.sens_y, ny, vel_y, rem_y);
        r.moved = (r.dx != 0) || (r.dy != 0);
      end
    end else begin
      vel_x = 0; vel_y = 0; rem_x = 0; rem_y = 0;
    end
    return r;
  endfunction

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // stream driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) moves_due.push_back(predict_move(cur_word));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_queue.size() > 0 && $urandom_range(99) >= gap_pct) begin
          cur_word = tx_queue.pop_front();
          s_axis_tvalid <= 1;
          s_axis_tuser  <= cur_word.op;
          s_axis_tdata  <= {1'b0, cur_word.val, cur_word.idx, cur_word.pitch, cur_word.yaw};
        end else begin
          s_axis_tvalid <= 0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    move_word_t want, got;
    if (!rst_ni) begin
      m_axis_tready <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.moved = m_axis_tuser;
        {got.sy, got.sx, got.dy, got.dx} = m_axis_tdata;
        if (moves_due.size() == 0) begin
          $error("unexpected word: tdata %h tuser %b", m_axis_tdata, m_axis_tuser);
          errors++;
        end else begin
          want = moves_due.pop_front();
          if (got.moved !== want.moved) begin
            $error("move_valid: expected %0d, got %0d", want.moved, got.moved); errors++;
          end
          if (got.dx !== want.dx) begin
            $error("mouse_dx: expected %0d, got %0d", want.dx, got.dx); errors++;
          end
          if (got.dy !== want.dy) begin
            $error("mouse_dy: expected %0d, got %0d", want.dy, got.dy); errors++;
          end
          if (got.sx !== want.sx) begin
            $error("stick_x: expected %0d, got %0d", want.sx, got.sx); errors++;
          end
          if (got.sy !== want.sy) begin
            $error("stick_y: expected %0d, got %0d", want.sy, got.sy); errors++;
          end
        end
      end
      m_axis_tready <= !hold_rx && ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] v);
    @(posedge clk_i);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_GYRO_MODE:  cfg.gyro_mode  = v[1:0];
      REG_FLAGS:      cfg.flags      = v[2:0];
      REG_DEADZONE:   cfg.deadzone   = v[14:0];
      REG_SENS_X:     cfg.sens_x     = v[15:0];
      REG_SENS_Y:     cfg.sens_y     = v[15:0];
      REG_SMOOTHING:  cfg.smoothing  = v[7:0];
      REG_BIAS_YAW:   cfg.bias_yaw   = v[15:0];
      default:        cfg.bias_pitch = v[15:0];
    endcase
  endtask

  task automatic settle();
    while (moves_due.size() > 0 || tx_queue.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  function automatic void push_sample(int y, int p);
    gyro_word_t w;
    w.op = OP_SAMPLE; w.yaw = y; w.pitch = p;
    w.idx = $urandom_range(127); w.val = $urandom;
    tx_queue.push_back(w);
  endfunction

  function automatic void push_entry(int i, int v);
    gyro_word_t w;
    w.op = OP_ENTRY; w.idx = i; w.val = v; w.yaw = $urandom; w.pitch = $urandom;
    tx_queue.push_back(w);
  endfunction

  function automatic int pick_rate();
    case ($urandom_range(4))
      0: return $urandom_range(1) ? 32767 : -32768;
      1: return int'(cfg.deadzone) + $urandom_range(600) - 300 + cfg.bias_yaw;
      2: return $urandom_range(4000) - 2000;
      default: return $signed(16'($urandom));
    endcase
  endfunction

  int unsigned dz;
  initial begin
    cfg = '{gyro_mode: MODE_OFF, flags: 0, deadzone: 0, sens_x: 256, sens_y: 256,
            smoothing: 0, bias_yaw: 0, bias_pitch: 0};
    vel_x = 0; vel_y = 0; rem_x = 0; rem_y = 0;
    errors = 0; gap_pct = 0; stall_pct = 0; hold_rx = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    rst_ni = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;

    // fill the whole curve before any curve read; include ignored indexes
    for (int i = 0; i <= POINTS; i++)
      push_entry(i, (i == 0) ? 0 : (i == POINTS) ? 65535 : i * 1000 + $urandom_range(500));
    push_entry(POINTS + 1, 16'h1234);
    push_entry(127, 16'hFFFF);
    push_sample(32767, -32768);
    settle();

    for (int ph = 0; ph < 9; ph++) begin
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 61; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 61; end
        default: begin gap_pct = 9; stall_pct = 9; end
      endcase
      case (ph)
        0: begin
          reg_write(REG_GYRO_MODE, MODE_JOY); reg_write(REG_FLAGS, 7);
          reg_write(REG_DEADZONE, 0); reg_write(REG_SENS_X, 65535);
          reg_write(REG_SENS_Y, 65535); reg_write(REG_SMOOTHING, 255);
          reg_write(REG_BIAS_YAW, 32'hFFFF8000); reg_write(REG_BIAS_PITCH, 32767);
        end
        1: begin
          reg_write(REG_GYRO_MODE, MODE_MOUSE); reg_write(REG_FLAGS, 0);
          reg_write(REG_DEADZONE, 32767); reg_write(REG_SENS_X, 0);
          reg_write(REG_SENS_Y, 65535); reg_write(REG_SMOOTHING, 0);
          reg_write(REG_BIAS_YAW, 0); reg_write(REG_BIAS_PITCH, 0);
        end
        5: reg_write(REG_GYRO_MODE, MODE_RSVD);
        6: reg_write(REG_GYRO_MODE, MODE_OFF);
        default: begin
          reg_write(REG_GYRO_MODE, (ph == 3) ? MODE_JOY : MODE_MOUSE);
          reg_write(REG_FLAGS, $urandom_range(7));
          dz = $urandom_range(2) == 0 ? $urandom_range(32767) : $urandom_range(3000);
          reg_write(REG_DEADZONE, dz);
          reg_write(REG_SENS_X, $urandom_range(1) ? $urandom_range(65535)
                                                    : $urandom_range(2048));
          reg_write(REG_SENS_Y, $urandom_range(1) ? $urandom_range(65535)
                                                    : $urandom_range(2048));
          reg_write(REG_SMOOTHING, $urandom_range(255));
          reg_write(REG_BIAS_YAW, $urandom_range(1) ? $urandom : $urandom_range(200));
          reg_write(REG_BIAS_PITCH, $urandom_range(1) ? $urandom : $urandom_range(200));
        end
      endcase

      // extremes of the rates in every setting
      push_sample(32767, 32767); push_sample(-32768, -32768);
      push_sample(0, 0); push_sample(1, -1);
      if (ph == 2) begin
        // long receiver hold-off while the sender keeps offering
        fork
          begin
            hold_rx = 1;
            repeat (900) @(posedge clk_i);
            hold_rx = 0;
          end
        join_none
      end
      for (int k = 0; k < 135; k++) begin
        if (k == 67) settle();
        if ($urandom_range(15) == 0)
          push_entry($urandom_range(3) == 0 ? $urandom_range(127) : $urandom_range(POINTS),
                     $urandom);
        else
          push_sample(pick_rate(), pick_rate());
      end
      settle();
    end

    repeat (300) @(posedge clk_i);
    if (errors == 0) $display("** gyro_to_pointer_converter: PASSED **");
    else $display("** gyro_to_pointer_converter: FAILED **");
    $finish;
  end

  initial begin
    #60_000_000;
    $display("** gyro_to_pointer_converter: FAILED **");
    $finish;
  end

endmodule
